// ----- rtl/itmpe_pkg.sv -----
// Shared constants, codes and control types of the inductor position error block.
package itmpe_pkg;

  localparam int SAMPLE_COUNT_DEF = 10;
  localparam int SAMPLE_BITS_DEF  = 12;

  localparam int NCH  = 3;
  localparam int CH_W = 2;
  localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
  localparam logic [CH_W-1:0] CH_MIDDLE = 2'd1;
  localparam logic [CH_W-1:0] CH_RIGHT  = 2'd2;

  localparam int CAL_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int GAIN_RESET = 100;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MIDDLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RIGHT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 3'd6;

  localparam int NORM_W    = 7;
  localparam int SIDE_W    = 8;
  localparam int TOTAL_W   = 9;
  localparam int ERR_W     = 16;
  localparam int PCT_FULL  = 100;
  localparam int PCT_FLOOR = 1;
  localparam int ERR_LIMIT = 25600;
  localparam int Q_FRAC    = 8;

  localparam int DIV_NUM_W      = 32;
  localparam int DIV_DEN_W      = 16;
  localparam int DIV_RADIX_BITS = 2;
  localparam int STEP_W         = $clog2(DIV_NUM_W / DIV_RADIX_BITS + 1);

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_MEAN = 2'd0;
  localparam logic [OP_W-1:0] OP_NORM = 2'd1;
  localparam logic [OP_W-1:0] OP_ERR  = 2'd2;

  typedef struct packed {
    logic            busy;
    logic            div_start;
    logic [OP_W-1:0] div_op;
    logic [CH_W-1:0] ch;
    logic            mean_load;
    logic            norm_load;
    logic            err_prep;
    logic            emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/itmpe_div.sv -----
// Shared iterative restoring divider, two quotient bits per cycle.
module itmpe_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [itmpe_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [itmpe_pkg::DIV_DEN_W-1:0] divisor,
  input  logic [itmpe_pkg::STEP_W-1:0]    steps,
  output logic                            done,
  output logic [itmpe_pkg::DIV_NUM_W-1:0] quotient
);
  import itmpe_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [STEP_W-1:0]    cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_NUM_W-1:0] quo_nxt;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_DEN_W:0]   shifted;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    shifted = '0;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      shifted = {rem_nxt, quo_nxt[DIV_NUM_W-1]};
      quo_nxt = {quo_nxt[DIV_NUM_W-2:0], 1'b0};
      if (shifted >= {1'b0, den_r}) begin
        shifted    = shifted - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = shifted[DIV_DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/itmpe_dp.sv -----
// Datapath: accumulators, calibration registers, shared divider and output word register.
module itmpe_dp #(
  parameter int SAMPLE_COUNT = itmpe_pkg::SAMPLE_COUNT_DEF,
  parameter int SAMPLE_BITS  = itmpe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [SAMPLE_BITS-1:0]            in_sample_left,
  input  logic [SAMPLE_BITS-1:0]            in_sample_middle,
  input  logic [SAMPLE_BITS-1:0]            in_sample_right,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [itmpe_pkg::NORM_W-1:0]      out_norm_left,
  output logic [itmpe_pkg::NORM_W-1:0]      out_norm_middle,
  output logic [itmpe_pkg::NORM_W-1:0]      out_norm_right,
  output logic [itmpe_pkg::SIDE_W-1:0]      out_side_strength,
  output logic [itmpe_pkg::TOTAL_W-1:0]     out_total_strength,
  output logic signed [itmpe_pkg::ERR_W-1:0] out_position_error,
  input  logic                              cfg_wr_en,
  input  logic [itmpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [itmpe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  itmpe_pkg::ctrl_cmd_t              cmd,
  output itmpe_pkg::dp_status_t             st
);
  import itmpe_pkg::*;

  localparam int CNT_W       = $clog2(SAMPLE_COUNT);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(SAMPLE_COUNT);
  localparam int MW          = (SAMPLE_BITS > CAL_W) ? SAMPLE_BITS : CAL_W;
  localparam int NORM_NUM_W  = MW + NORM_W;
  localparam int ERR_NUM_W   = GAIN_W + NORM_W;
  localparam int MEAN_STEPS  = (SUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int NORM_STEPS  = (NORM_NUM_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int ERR_STEPS   = (ERR_NUM_W + Q_FRAC + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
  localparam int MEAN_SH     = DIV_NUM_W - DIV_RADIX_BITS * MEAN_STEPS;
  localparam int NORM_SH     = DIV_NUM_W - DIV_RADIX_BITS * NORM_STEPS;
  localparam int ERR_SH      = DIV_NUM_W - DIV_RADIX_BITS * ERR_STEPS + Q_FRAC;
  localparam int TRIM_DIV    = SAMPLE_COUNT - 2;

  logic [SAMPLE_BITS-1:0] samp [NCH];
  logic [CNT_W-1:0]       cnt_r;
  logic [SUM_W-1:0]       sum_r  [NCH];
  logic [SAMPLE_BITS-1:0] smin_r [NCH];
  logic [SAMPLE_BITS-1:0] smax_r [NCH];
  logic [SUM_W-1:0]       sum_nxt  [NCH];
  logic [SAMPLE_BITS-1:0] smin_nxt [NCH];
  logic [SAMPLE_BITS-1:0] smax_nxt [NCH];
  logic [SUM_W-1:0]       t_nxt  [NCH];
  logic [SUM_W-1:0]       t_r    [NCH];
  logic                   last;
  logic                   in_accept;
  logic                   frame_done;

  logic [CAL_W-1:0]       cal_lo_r [NCH];
  logic [CAL_W-1:0]       cal_hi_r [NCH];
  logic [GAIN_W-1:0]      gain_r;

  logic [SAMPLE_BITS-1:0] mean_r;
  logic [NORM_W-1:0]      norm_r [NCH];
  logic [NORM_W-1:0]      norm_val;
  logic [MW-1:0]          mean_ext;
  logic [MW-1:0]          lo_ext;
  logic [MW-1:0]          hi_ext;
  logic [NORM_NUM_W-1:0]  norm_num;

  logic [NORM_W-1:0]      diff_mag;
  logic                   neg_r;
  logic [ERR_NUM_W-1:0]   num_r;
  logic [DIV_DEN_W-1:0]   den_r;
  logic [TOTAL_W-1:0]     total_sum;
  logic [ERR_W-1:0]       err_clamp;
  logic [ERR_W-1:0]       err_mag;
  logic [ERR_W-1:0]       err_val;

  logic                   div_done;
  logic [DIV_NUM_W-1:0]   div_quo;
  logic [DIV_NUM_W-1:0]   div_dividend;
  logic [DIV_DEN_W-1:0]   div_divisor;
  logic [STEP_W-1:0]      div_steps;

  logic                   out_valid_r;
  logic [NORM_W-1:0]      out_norm_r [NCH];
  logic [SIDE_W-1:0]      out_side_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic [ERR_W-1:0]       out_err_r;

  assign samp[CH_LEFT]   = in_sample_left;
  assign samp[CH_MIDDLE] = in_sample_middle;
  assign samp[CH_RIGHT]  = in_sample_right;

  assign last       = (cnt_r == CNT_W'(SAMPLE_COUNT - 1));
  assign in_stall   = last && cmd.busy;
  assign in_accept  = in_valid && !in_stall;
  assign frame_done = in_accept && last;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum_nxt[c]  = sum_r[c] + SUM_W'(samp[c]);
      smin_nxt[c] = (samp[c] < smin_r[c]) ? samp[c] : smin_r[c];
      smax_nxt[c] = (samp[c] > smax_r[c]) ? samp[c] : smax_r[c];
      t_nxt[c]    = sum_nxt[c] - SUM_W'(smin_nxt[c]) - SUM_W'(smax_nxt[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      for (int c = 0; c < NCH; c++) begin
        sum_r[c]  <= '0;
        smin_r[c] <= '1;
        smax_r[c] <= '0;
      end
    end else if (in_accept) begin
      if (last) begin
        cnt_r <= '0;
        for (int c = 0; c < NCH; c++) begin
          sum_r[c]  <= '0;
          smin_r[c] <= '1;
          smax_r[c] <= '0;
        end
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        for (int c = 0; c < NCH; c++) begin
          sum_r[c]  <= sum_nxt[c];
          smin_r[c] <= smin_nxt[c];
          smax_r[c] <= smax_nxt[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      for (int c = 0; c < NCH; c++) begin
        t_r[c] <= t_nxt[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NCH; c++) begin
        cal_lo_r[c] <= '0;
        cal_hi_r[c] <= '1;
      end
      gain_r <= GAIN_W'(GAIN_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_LEFT:   cal_lo_r[CH_LEFT]   <= cfg_wdata[CAL_W-1:0];
        REG_MAX_LEFT:   cal_hi_r[CH_LEFT]   <= cfg_wdata[CAL_W-1:0];
        REG_MIN_MIDDLE: cal_lo_r[CH_MIDDLE] <= cfg_wdata[CAL_W-1:0];
        REG_MAX_MIDDLE: cal_hi_r[CH_MIDDLE] <= cfg_wdata[CAL_W-1:0];
        REG_MIN_RIGHT:  cal_lo_r[CH_RIGHT]  <= cfg_wdata[CAL_W-1:0];
        REG_MAX_RIGHT:  cal_hi_r[CH_RIGHT]  <= cfg_wdata[CAL_W-1:0];
        REG_ERROR_GAIN: gain_r              <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign mean_ext = MW'(mean_r);
  assign lo_ext   = MW'(cal_lo_r[cmd.ch]);
  assign hi_ext   = MW'(cal_hi_r[cmd.ch]);
  assign norm_num = NORM_NUM_W'(mean_ext - lo_ext) * NORM_NUM_W'(PCT_FULL);

  always_comb begin
    case (cmd.div_op)
      OP_MEAN: begin
        div_dividend = DIV_NUM_W'(t_r[cmd.ch]) << MEAN_SH;
        div_divisor  = DIV_DEN_W'(TRIM_DIV);
        div_steps    = STEP_W'(MEAN_STEPS);
      end
      OP_NORM: begin
        div_dividend = DIV_NUM_W'(norm_num) << NORM_SH;
        div_divisor  = DIV_DEN_W'(hi_ext - lo_ext);
        div_steps    = STEP_W'(NORM_STEPS);
      end
      OP_ERR: begin
        div_dividend = DIV_NUM_W'(num_r) << ERR_SH;
        div_divisor  = den_r;
        div_steps    = STEP_W'(ERR_STEPS);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_steps    = '0;
      end
    endcase
  end

  itmpe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    if (mean_ext < lo_ext) begin
      norm_val = NORM_W'(PCT_FLOOR);
    end else if (hi_ext <= lo_ext) begin
      norm_val = NORM_W'(PCT_FULL);
    end else if (div_quo > DIV_NUM_W'(PCT_FULL)) begin
      norm_val = NORM_W'(PCT_FULL);
    end else begin
      norm_val = div_quo[NORM_W-1:0];
    end
  end

  assign diff_mag = (norm_r[CH_LEFT] < norm_r[CH_RIGHT]) ?
                    (norm_r[CH_RIGHT] - norm_r[CH_LEFT]) :
                    (norm_r[CH_LEFT] - norm_r[CH_RIGHT]);
  assign total_sum = TOTAL_W'(norm_r[CH_LEFT]) + TOTAL_W'(norm_r[CH_MIDDLE]) +
                     TOTAL_W'(norm_r[CH_RIGHT]);

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mean_r <= div_quo[SAMPLE_BITS-1:0];
    end
    if (cmd.norm_load) begin
      norm_r[cmd.ch] <= norm_val;
    end
    if (cmd.err_prep) begin
      neg_r <= norm_r[CH_LEFT] < norm_r[CH_RIGHT];
      num_r <= ERR_NUM_W'(gain_r) * ERR_NUM_W'(diff_mag);
      den_r <= DIV_DEN_W'(total_sum) * DIV_DEN_W'(norm_r[CH_MIDDLE]);
    end
  end

  assign err_clamp = (div_quo > DIV_NUM_W'(ERR_LIMIT)) ? ERR_W'(ERR_LIMIT) :
                     div_quo[ERR_W-1:0];

  always_comb begin
    if (den_r == '0) begin
      err_mag = (num_r == '0) ? '0 : ERR_W'(ERR_LIMIT);
    end else begin
      err_mag = err_clamp;
    end
    err_val = neg_r ? (ERR_W'(0) - err_mag) : err_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int c = 0; c < NCH; c++) begin
        out_norm_r[c] <= norm_r[c];
      end
      out_side_r  <= SIDE_W'(norm_r[CH_LEFT]) + SIDE_W'(norm_r[CH_RIGHT]);
      out_total_r <= total_sum;
      out_err_r   <= err_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_norm_left      = out_norm_r[CH_LEFT];
  assign out_norm_middle    = out_norm_r[CH_MIDDLE];
  assign out_norm_right     = out_norm_r[CH_RIGHT];
  assign out_side_strength  = out_side_r;
  assign out_total_strength = out_total_r;
  assign out_position_error = out_err_r;

  assign st.frame_done = frame_done;
  assign st.div_done   = div_done;
  assign st.out_free   = !out_valid_r || !out_stall;

  a_stall_only_at_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> last)
    else $error("input stalled before the last word of a frame");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || !out_stall))
    else $error("result written over an untaken output word");

  a_min_not_above_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (smin_r[CH_LEFT] <= smax_r[CH_LEFT]))
    else $error("running minimum above running maximum");

endmodule

// ----- rtl/itmpe_ctrl.sv -----
// Controller that sequences the per-frame mean, normalization and error divisions.
module itmpe_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itmpe_pkg::dp_status_t st,
  output itmpe_pkg::ctrl_cmd_t  cmd
);
  import itmpe_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
  localparam logic [ST_W-1:0] S_MEAN     = 4'd1;
  localparam logic [ST_W-1:0] S_MEAN_W   = 4'd2;
  localparam logic [ST_W-1:0] S_NORM     = 4'd3;
  localparam logic [ST_W-1:0] S_NORM_W   = 4'd4;
  localparam logic [ST_W-1:0] S_ERR_PREP = 4'd5;
  localparam logic [ST_W-1:0] S_ERR      = 4'd6;
  localparam logic [ST_W-1:0] S_ERR_W    = 4'd7;
  localparam logic [ST_W-1:0] S_EMIT     = 4'd8;

  logic [ST_W-1:0] state_r;
  logic [ST_W-1:0] state_nxt;
  logic [CH_W-1:0] ch_r;
  logic [CH_W-1:0] ch_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cmd           = '0;
    cmd.busy      = (state_r != S_IDLE);
    cmd.ch        = ch_r;
    cmd.div_op    = OP_MEAN;
    case (state_r)
      S_IDLE: begin
        ch_nxt = CH_LEFT;
        if (st.frame_done) begin
          state_nxt = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_MEAN;
        state_nxt     = S_MEAN_W;
      end
      S_MEAN_W: begin
        if (st.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = S_NORM;
        end
      end
      S_NORM: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_NORM;
        state_nxt     = S_NORM_W;
      end
      S_NORM_W: begin
        cmd.div_op = OP_NORM;
        if (st.div_done) begin
          cmd.norm_load = 1'b1;
          if (ch_r == CH_RIGHT) begin
            state_nxt = S_ERR_PREP;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = S_MEAN;
          end
        end
      end
      S_ERR_PREP: begin
        cmd.err_prep = 1'b1;
        state_nxt    = S_ERR;
      end
      S_ERR: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = OP_ERR;
        state_nxt     = S_ERR_W;
      end
      S_ERR_W: begin
        if (st.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= CH_LEFT;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_frame_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st.frame_done |-> (state_r == S_IDLE))
    else $error("frame completed while the previous one is still in progress");

  a_done_only_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    st.div_done |-> (state_r == S_MEAN_W || state_r == S_NORM_W || state_r == S_ERR_W))
    else $error("divider finished outside a wait state");

endmodule

// ----- rtl/inductor_trimmed_mean_position_error.sv -----
// Top level of the inductor trimmed-mean position error block.
// Each input word is one round of left, middle and right samples and is taken in one cycle unless the input is stalled.
// After SAMPLE_COUNT words the block drops each channel's largest and smallest sample,
// averages the rest, normalizes the means to percent against the calibration registers and
// delivers one output word with the strengths and the Q8 lateral error; other input words
// give no output. All divisions run on one shared divider that retires two quotient bits a
// cycle: a mean and a normalization division for each channel in turn, then the error
// division. The first words of the next frame are taken meanwhile; its last word is
// stalled until the previous frame's result has been written to the output register,
// which waits until that register has room.
module inductor_trimmed_mean_position_error #(
  parameter int SAMPLE_COUNT = itmpe_pkg::SAMPLE_COUNT_DEF,
  parameter int SAMPLE_BITS  = itmpe_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [SAMPLE_BITS-1:0]             in_sample_left,
  input  logic [SAMPLE_BITS-1:0]             in_sample_middle,
  input  logic [SAMPLE_BITS-1:0]             in_sample_right,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [itmpe_pkg::NORM_W-1:0]       out_norm_left,
  output logic [itmpe_pkg::NORM_W-1:0]       out_norm_middle,
  output logic [itmpe_pkg::NORM_W-1:0]       out_norm_right,
  output logic [itmpe_pkg::SIDE_W-1:0]       out_side_strength,
  output logic [itmpe_pkg::TOTAL_W-1:0]      out_total_strength,
  output logic signed [itmpe_pkg::ERR_W-1:0] out_position_error,
  input  logic                               cfg_wr_en,
  input  logic [itmpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itmpe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import itmpe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  itmpe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  itmpe_dp #(
    .SAMPLE_COUNT (SAMPLE_COUNT),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_left     (in_sample_left),
    .in_sample_middle   (in_sample_middle),
    .in_sample_right    (in_sample_right),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_norm_left      (out_norm_left),
    .out_norm_middle    (out_norm_middle),
    .out_norm_right     (out_norm_right),
    .out_side_strength  (out_side_strength),
    .out_total_strength (out_total_strength),
    .out_position_error (out_position_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .st                 (st)
  );

endmodule

// ----- tb/tb_inductor_trimmed_mean_position_error.sv -----
// Self-checking testbench for the inductor trimmed-mean position error block.
`timescale 1ns / 100ps

module tb_inductor_trimmed_mean_position_error;
  import itmpe_pkg::*;

  localparam int FRAME_LEN     = SAMPLE_COUNT_DEF;
  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX    = (1 << SW) - 1;
  localparam int SETTLE_CYCLES = 150;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef logic [CFG_DATA_W-1:0] reg_words_t [REG_ERROR_GAIN+1];

  typedef struct packed {
    logic [NORM_W-1:0]       norm_l;
    logic [NORM_W-1:0]       norm_m;
    logic [NORM_W-1:0]       norm_r;
    logic [SIDE_W-1:0]       side;
    logic [TOTAL_W-1:0]      total;
    logic signed [ERR_W-1:0] err;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SW-1:0] in_sample_left = '0;
  logic [SW-1:0] in_sample_middle = '0;
  logic [SW-1:0] in_sample_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [NORM_W-1:0] out_norm_left;
  logic [NORM_W-1:0] out_norm_middle;
  logic [NORM_W-1:0] out_norm_right;
  logic [SIDE_W-1:0] out_side_strength;
  logic [TOTAL_W-1:0] out_total_strength;
  logic signed [ERR_W-1:0] out_position_error;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state: calibration copy and the running frame accumulators.
  logic [CAL_W-1:0]  cal_lo [NCH] = '{default: '0};
  logic [CAL_W-1:0]  cal_hi [NCH] = '{default: '1};
  logic [GAIN_W-1:0] gain = GAIN_RESET;
  logic [15:0]       acc_sum [NCH] = '{default: '0};
  logic [SW-1:0]     acc_min [NCH] = '{default: '1};
  logic [SW-1:0]     acc_max [NCH] = '{default: '0};
  int                rounds = 0;

  frame_result_t expected_frames[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  stall_budget = 0;
  bit  in_gaps = 1'b0;
  bit  out_gaps = 1'b0;

  inductor_trimmed_mean_position_error dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample_left     (in_sample_left),
    .in_sample_middle   (in_sample_middle),
    .in_sample_right    (in_sample_right),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_norm_left      (out_norm_left),
    .out_norm_middle    (out_norm_middle),
    .out_norm_right     (out_norm_right),
    .out_side_strength  (out_side_strength),
    .out_total_strength (out_total_strength),
    .out_position_error (out_position_error),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic logic [NORM_W-1:0] percent_of(int unsigned mean, int unsigned lo,
                                                   int unsigned hi);
    int unsigned q;
    if (mean < lo) return PCT_FLOOR;
    if (hi <= lo) return PCT_FULL;
    q = (PCT_FULL * (mean - lo)) / (hi - lo);
    return (q > PCT_FULL) ? PCT_FULL : q;
  endfunction

  function automatic logic signed [ERR_W-1:0] error_q8(int l, int m, int r);
    longint num, den, mag, q;
    num = longint'(gain) * (l - r);
    den = longint'(l + m + r) * m;
    if (den == 0) return (num > 0) ? ERR_LIMIT : ((num < 0) ? -ERR_LIMIT : 0);
    mag = ((num < 0) ? -num : num) << Q_FRAC;
    q = mag / den;
    if (q > ERR_LIMIT) q = ERR_LIMIT;
    return (num < 0) ? -q : q;
  endfunction

  task automatic absorb_round(input logic [SW-1:0] l, m, r);
    logic [SW-1:0] s [NCH];
    int unsigned pct [NCH];
    frame_result_t res;
    s[CH_LEFT] = l;
    s[CH_MIDDLE] = m;
    s[CH_RIGHT] = r;
    for (int c = 0; c < NCH; c++) begin
      acc_sum[c] += s[c];
      if (s[c] < acc_min[c]) acc_min[c] = s[c];
      if (s[c] > acc_max[c]) acc_max[c] = s[c];
    end
    rounds++;
    if (rounds == FRAME_LEN) begin
      for (int c = 0; c < NCH; c++) begin
        pct[c] = percent_of((int'(acc_sum[c]) - acc_min[c] - acc_max[c]) / (FRAME_LEN - 2),
                            cal_lo[c], cal_hi[c]);
        acc_sum[c] = '0;
        acc_min[c] = '1;
        acc_max[c] = '0;
      end
      rounds = 0;
      res.norm_l = pct[CH_LEFT];
      res.norm_m = pct[CH_MIDDLE];
      res.norm_r = pct[CH_RIGHT];
      res.side = pct[CH_LEFT] + pct[CH_RIGHT];
      res.total = pct[CH_LEFT] + pct[CH_MIDDLE] + pct[CH_RIGHT];
      res.err = error_q8(pct[CH_LEFT], pct[CH_MIDDLE], pct[CH_RIGHT]);
      expected_frames.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        note_mismatch("output word with no frame outstanding");
      end else begin
        want = expected_frames.pop_front();
        if (out_norm_left !== want.norm_l)
          note_mismatch($sformatf("norm_left %0d, expected %0d", out_norm_left, want.norm_l));
        if (out_norm_middle !== want.norm_m)
          note_mismatch($sformatf("norm_middle %0d, expected %0d", out_norm_middle,
                                  want.norm_m));
        if (out_norm_right !== want.norm_r)
          note_mismatch($sformatf("norm_right %0d, expected %0d", out_norm_right,
                                  want.norm_r));
        if (out_side_strength !== want.side)
          note_mismatch($sformatf("side_strength %0d, expected %0d", out_side_strength,
                                  want.side));
        if (out_total_strength !== want.total)
          note_mismatch($sformatf("total_strength %0d, expected %0d", out_total_strength,
                                  want.total));
        if (out_position_error !== want.err)
          note_mismatch($sformatf("position_error %0d, expected %0d", out_position_error,
                                  want.err));
      end
    end
    out_stall <= (stall_budget > 0) || (out_gaps && $urandom_range(99) < 12);
    if (stall_budget > 0) stall_budget--;
  end

  task automatic send_word(input logic [SW-1:0] l, m, r);
    if (in_gaps && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_left <= l;
    in_sample_middle <= m;
    in_sample_right <= r;
    do @(posedge clk); while (in_stall);
    absorb_round(l, m, r);
  endtask

  task automatic send_frame(input int l_lo, l_hi, m_lo, m_hi, r_lo, r_hi);
    repeat (FRAME_LEN)
      send_word($urandom_range(l_hi, l_lo), $urandom_range(m_hi, m_lo),
                $urandom_range(r_hi, r_lo));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  function automatic reg_words_t make_cal(input int lo_l, hi_l, lo_m, hi_m, lo_r, hi_r, g);
    reg_words_t w;
    w[REG_MIN_LEFT] = lo_l;
    w[REG_MAX_LEFT] = hi_l;
    w[REG_MIN_MIDDLE] = lo_m;
    w[REG_MAX_MIDDLE] = hi_m;
    w[REG_MIN_RIGHT] = lo_r;
    w[REG_MAX_RIGHT] = hi_r;
    w[REG_ERROR_GAIN] = g;
    return w;
  endfunction

  task automatic program_cal(input reg_words_t w);
    logic [CFG_DATA_W-1:0] data;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = REG_MIN_LEFT; i <= REG_ERROR_GAIN; i++) begin
      data = w[i];
      if (i != REG_ERROR_GAIN) data[CFG_DATA_W-1:CAL_W] = $urandom;
      cfg_wr_en <= 1'b1;
      cfg_index <= i;
      cfg_wdata <= data;
      @(posedge clk);
      case (i)
        REG_MIN_LEFT:   cal_lo[CH_LEFT] = data[CAL_W-1:0];
        REG_MAX_LEFT:   cal_hi[CH_LEFT] = data[CAL_W-1:0];
        REG_MIN_MIDDLE: cal_lo[CH_MIDDLE] = data[CAL_W-1:0];
        REG_MAX_MIDDLE: cal_hi[CH_MIDDLE] = data[CAL_W-1:0];
        REG_MIN_RIGHT:  cal_lo[CH_RIGHT] = data[CAL_W-1:0];
        REG_MAX_RIGHT:  cal_hi[CH_RIGHT] = data[CAL_W-1:0];
        default:        gain = data;
      endcase
    end
    // The unused index must leave every register alone.
    cfg_index <= REG_SPARE;
    cfg_wdata <= $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    for (int k = 0; k < FRAME_LEN; k++) begin
      if (k % 2 == 0) send_word(SAMPLE_MAX, 0, 0);
      else send_word(0, SAMPLE_MAX, SAMPLE_MAX);
    end
    for (int k = 0; k < FRAME_LEN; k++)
      send_word(SAMPLE_MAX - 455 * k, 455 * k, SAMPLE_MAX);
  endtask

  task automatic test_calibration_corners();
    logic [SW-1:0] v;
    program_cal(make_cal(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX, 0));
    send_frame(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX);
    program_cal(make_cal(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX, 16'hFFFF));
    send_frame(3000, SAMPLE_MAX, 200, 600, 0, 800);
    send_frame(0, 800, 200, 600, 3000, SAMPLE_MAX);
    program_cal(make_cal(2048, 2048, 0, SAMPLE_MAX, 3000, 1000, GAIN_RESET));
    send_frame(0, 1500, 0, SAMPLE_MAX, 0, 1500);
    send_frame(2500, SAMPLE_MAX, 0, SAMPLE_MAX, 3200, SAMPLE_MAX);
    program_cal(make_cal(1000, 1100, 1000, 1100, 1000, 1100, 250));
    send_frame(1200, SAMPLE_MAX, 1000, 1100, 0, 900);
    send_frame(0, 999, 1101, SAMPLE_MAX, 1000, 1100);
    // A middle strength of zero leaves the error with no denominator.
    program_cal(make_cal(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX, GAIN_RESET));
    send_frame(2000, SAMPLE_MAX, 0, 40, 0, 1000);
    send_frame(0, 1000, 0, 40, 2000, SAMPLE_MAX);
    send_frame(0, 0, 0, 0, 0, 0);
    repeat (FRAME_LEN) begin
      v = $urandom;
      send_word(v, $urandom_range(40), v);
    end
  endtask

  task automatic test_random_frames();
    int lo [NCH];
    int hi [NCH];
    int g;
    int centre, spread;
    for (int phase = 0; phase < 10; phase++) begin
      in_gaps = (phase != 0);
      out_gaps = (phase != 0);
      for (int c = 0; c < NCH; c++) begin
        case ($urandom_range(9))
          0: begin
            hi[c] = $urandom_range(SAMPLE_MAX);
            lo[c] = $urandom_range(SAMPLE_MAX, hi[c]);
          end
          1: begin
            lo[c] = 0;
            hi[c] = SAMPLE_MAX;
          end
          default: begin
            lo[c] = $urandom_range(3000);
            hi[c] = lo[c] + $urandom_range(SAMPLE_MAX - lo[c]);
          end
        endcase
      end
      case ($urandom_range(5))
        0: g = 0;
        1: g = 16'hFFFF;
        2: g = $urandom_range(16'hFFFF);
        default: g = $urandom_range(400);
      endcase
      program_cal(make_cal(lo[CH_LEFT], hi[CH_LEFT], lo[CH_MIDDLE], hi[CH_MIDDLE],
                           lo[CH_RIGHT], hi[CH_RIGHT], g));
      repeat (10) begin
        for (int c = 0; c < NCH; c++) begin
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              lo[c] = 0;
              hi[c] = SAMPLE_MAX;
            end
            9: begin
              lo[c] = 0;
              hi[c] = 60;
            end
            default: begin
              centre = $urandom_range(SAMPLE_MAX);
              spread = $urandom_range(400);
              lo[c] = (centre > spread) ? centre - spread : 0;
              hi[c] = (centre + spread < SAMPLE_MAX) ? centre + spread : SAMPLE_MAX;
            end
          endcase
        end
        send_frame(lo[CH_LEFT], hi[CH_LEFT], lo[CH_MIDDLE], hi[CH_MIDDLE],
                   lo[CH_RIGHT], hi[CH_RIGHT]);
      end
    end
  endtask

  task automatic test_output_holdoff();
    wait_drained();
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    stall_budget = 600;
    repeat (4) send_frame(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX);
    wait_drained();
    send_frame(0, SAMPLE_MAX, 0, SAMPLE_MAX, 0, SAMPLE_MAX);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_calibration_corners();
    test_random_frames();
    test_output_holdoff();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/itmpe_pkg.sv
rtl/itmpe_div.sv
rtl/itmpe_dp.sv
rtl/itmpe_ctrl.sv
rtl/inductor_trimmed_mean_position_error.sv
tb/tb_inductor_trimmed_mean_position_error.sv
